### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/lls_pkg.sv
`default_nettype none

package lls_pkg;

    localparam int SERVER_COUNT = 8;
    localparam int IDX_W        = 3;
    localparam int TREE_LEAVES  = 1 << IDX_W;
    localparam int RANK_W       = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;
    localparam int DATA_W       = 16;
    localparam int CFG_INDEX_W  = 4;

    typedef logic [DATA_W-1:0] load_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;

    // decision for the request in the input register
    typedef struct packed {
        logic  fits;
        idx_t  idx;
        load_t new_load;
        rank_t old_rank;
    } pick_t;

    // state update applied at the clock edge
    typedef struct packed {
        logic  en;
        idx_t  idx;
        load_t new_load;
        rank_t old_rank;
    } upd_t;

endpackage

`default_nettype wire

### rtl/least_loaded_server_assigner_core.sv
// least-loaded server assigner
//
// request channel: request_valid/request_ready with request_tag and
// request_size. result channel: result_valid/result_ready with accepted,
// server_index and result_tag. one result per request, in request order.
// capacity_0..7 are written through cfg_write/cfg_index/cfg_data; an index of
// 8 or more is dropped. write them only while no request is in flight.
//
// a request in the input register moves to the result register once that is
// free or its result is taken. throughput is one request per cycle while
// the receiver takes results: the minimum tree over the server loads, the
// capacity compare and the state update all sit between those two registers.
//
// reset clears loads to zero, sets recency ranks to the server index and all
// capacities to 65535. when the receiver stalls, the result register holds
// and one more request is taken into the input register; request_ready then
// drops until the result is taken.
`default_nettype none

module least_loaded_server_assigner_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_write,
    input  wire  lls_pkg::cfg_idx_t cfg_index,
    input  wire  lls_pkg::load_t cfg_data,
    input  wire                  request_valid,
    output logic                 request_ready,
    input  wire  lls_pkg::load_t request_tag,
    input  wire  lls_pkg::load_t request_size,
    output logic                 result_valid,
    input  wire                  result_ready,
    output logic                 accepted,
    output lls_pkg::idx_t        server_index,
    output lls_pkg::load_t       result_tag
);
    import lls_pkg::*;

    logic  s1_valid_reg;
    load_t s1_tag_reg;
    load_t s1_size_reg;

    logic  result_valid_reg;
    logic  accepted_reg;
    idx_t  server_index_reg;
    load_t result_tag_reg;

    logic  out_open;
    logic  advance;
    pick_t pick;
    upd_t  upd;

    logic [SERVER_COUNT-1:0][DATA_W-1:0] loads;
    logic [SERVER_COUNT-1:0][RANK_W-1:0] ranks;
    logic [SERVER_COUNT-1:0][DATA_W-1:0] caps;

    assign out_open      = !result_valid_reg || result_ready;
    assign advance       = s1_valid_reg && out_open;
    assign request_ready = !s1_valid_reg || out_open;

    always_comb
    begin
        upd.en       = advance && pick.fits;
        upd.idx      = pick.idx;
        upd.new_load = pick.new_load;
        upd.old_rank = pick.old_rank;
    end

    lls_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .upd       (upd),
        .loads     (loads),
        .ranks     (ranks),
        .caps      (caps)
    );

    lls_select u_select (
        .loads (loads),
        .ranks (ranks),
        .caps  (caps),
        .size  (s1_size_reg),
        .pick  (pick)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (request_ready)
        begin
            s1_valid_reg <= request_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request_valid && request_ready)
        begin
            s1_tag_reg  <= request_tag;
            s1_size_reg <= request_size;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg     <= pick.fits;
            server_index_reg <= pick.fits ? pick.idx : '0;
            result_tag_reg   <= s1_tag_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign accepted     = accepted_reg;
    assign server_index = server_index_reg;
    assign result_tag   = result_tag_reg;

endmodule

`default_nettype wire

### rtl/lls_state.sv
`default_nettype none

module lls_state (
    input  wire                                            clk,
    input  wire                                            rst_n,
    input  wire                                            cfg_write,
    input  wire  lls_pkg::cfg_idx_t                        cfg_index,
    input  wire  lls_pkg::load_t                           cfg_data,
    input  wire  lls_pkg::upd_t                            upd,
    output logic [lls_pkg::SERVER_COUNT-1:0][lls_pkg::DATA_W-1:0] loads,
    output logic [lls_pkg::SERVER_COUNT-1:0][lls_pkg::RANK_W-1:0] ranks,
    output logic [lls_pkg::SERVER_COUNT-1:0][lls_pkg::DATA_W-1:0] caps
);
    import lls_pkg::*;

    load_t cap_reg  [SERVER_COUNT];
    load_t load_reg [SERVER_COUNT];
    rank_t rank_reg [SERVER_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SERVER_COUNT; i++)
            begin
                cap_reg[i] <= '1;
            end
        end
        else if (cfg_write)
        begin
            // indexes beyond the server count are dropped
            for (int i = 0; i < SERVER_COUNT; i++)
            begin
                if (cfg_index == cfg_idx_t'(i))
                begin
                    cap_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SERVER_COUNT; i++)
            begin
                load_reg[i] <= '0;
                rank_reg[i] <= rank_t'(i);
            end
        end
        else if (upd.en)
        begin
            for (int i = 0; i < SERVER_COUNT; i++)
            begin
                if (upd.idx == idx_t'(i))
                begin
                    load_reg[i] <= upd.new_load;
                    rank_reg[i] <= rank_t'(SERVER_COUNT - 1);
                end
                else if (rank_reg[i] > upd.old_rank)
                begin
                    rank_reg[i] <= rank_reg[i] - 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SERVER_COUNT; i++)
        begin
            loads[i] = load_reg[i];
            ranks[i] = rank_reg[i];
            caps[i]  = cap_reg[i];
        end
    end

endmodule

`default_nettype wire

### rtl/lls_select.sv
`default_nettype none

module lls_select (
    input  wire  [lls_pkg::SERVER_COUNT-1:0][lls_pkg::DATA_W-1:0] loads,
    input  wire  [lls_pkg::SERVER_COUNT-1:0][lls_pkg::RANK_W-1:0] ranks,
    input  wire  [lls_pkg::SERVER_COUNT-1:0][lls_pkg::DATA_W-1:0] caps,
    input  wire  lls_pkg::load_t                                  size,
    output lls_pkg::pick_t                                        pick
);
    import lls_pkg::*;

    typedef struct packed {
        logic  valid;
        load_t load;
        rank_t rank;
        idx_t  idx;
    } cand_t;

    cand_t               node [2*TREE_LEAVES];
    cand_t               best;
    load_t               best_cap;
    logic [DATA_W:0]     sum;

    // binary tree: left child holds lower indexes and wins ties,
    // key is load then recency rank
    always_comb
    begin
        for (int n = 0; n < 2*TREE_LEAVES; n++)
        begin
            node[n] = '0;
        end
        for (int i = 0; i < SERVER_COUNT; i++)
        begin
            node[TREE_LEAVES + i].valid = 1'b1;
            node[TREE_LEAVES + i].load  = loads[i];
            node[TREE_LEAVES + i].rank  = ranks[i];
            node[TREE_LEAVES + i].idx   = idx_t'(i);
        end
        for (int n = TREE_LEAVES - 1; n >= 1; n--)
        begin
            if (node[2*n].valid && (!node[2*n+1].valid ||
                {node[2*n].load, node[2*n].rank} <= {node[2*n+1].load, node[2*n+1].rank}))
            begin
                node[n] = node[2*n];
            end
            else
            begin
                node[n] = node[2*n+1];
            end
        end
    end

    assign best     = node[1];
    assign best_cap = caps[best.idx];
    assign sum      = {1'b0, best.load} + {1'b0, size};

    always_comb
    begin
        pick.fits     = (sum <= {1'b0, best_cap});
        pick.idx      = best.idx;
        pick.new_load = sum[DATA_W-1:0];
        pick.old_rank = best.rank;
    end

endmodule

`default_nettype wire

### rtl/lls_checker.sv
`default_nettype none

`include "assert_macros.svh"

module lls_checker (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     request_ready,
    input  wire                     result_valid,
    input  wire                     result_ready,
    input  wire                     accepted,
    input  wire  lls_pkg::idx_t     server_index,
    input  wire  lls_pkg::load_t    result_tag
);
    import lls_pkg::*;

    logic                      stalled;
    logic [DATA_W+IDX_W:0]     payload;

    assign stalled = result_valid && !result_ready;
    assign payload = {accepted, server_index, result_tag};

    // a stalled result keeps its payload
    `LLS_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(payload))

    // a rejected request reports server zero
    `LLS_ASSERT_IMPL(a_reject_index, result_valid && !accepted, server_index == '0)

    // with the result side empty the block always takes a request
    `LLS_ASSERT_IMPL(a_ready_when_empty, !result_valid, request_ready)

    // the input side only closes behind a stalled result
    `LLS_ASSERT_IMPL(a_ready_low_on_stall, !request_ready, stalled)

endmodule

bind least_loaded_server_assigner_core lls_checker u_lls_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;

    import lls_pkg::*;

    typedef enum cfg_idx_t {
        CAPACITY_0, CAPACITY_1, CAPACITY_2, CAPACITY_3,
        CAPACITY_4, CAPACITY_5, CAPACITY_6, CAPACITY_7
    } capacity_reg_e;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_e;

    typedef struct packed {
        logic  accepted;
        idx_t  server;
        load_t tag;
    } assignment_t;

    // a request row carries tag and size, a write row carries index and data
    typedef struct {
        row_kind_e kind;
        load_t     tag_idx;
        load_t     size_data;
        bit        typed;
        logic      want_acc;
        idx_t      want_idx;
    } plan_row_t;

    localparam int CAPACITY_REGS    = 8;
    localparam int FIRST_UNUSED_IDX = 8;
    localparam int LAST_UNUSED_IDX  = 15;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 206;
    localparam int DRAIN_PHASE      = 2;
    localparam int HOLD_PHASE       = 3;
    localparam int HOLD_CYCLES      = 80;
    localparam int SETTLE_CYCLES    = 4;
    localparam int STALL_LIMIT      = 2000;
    localparam int MAX_REPORTS      = 10;
    localparam int PLAN_ROWS        = 25;

    logic     clk;
    logic     rst_n;
    logic     cfg_write;
    cfg_idx_t cfg_index;
    load_t    cfg_data;
    logic     request_valid;
    logic     request_ready;
    load_t    request_tag;
    load_t    request_size;
    logic     result_valid;
    logic     result_ready;
    logic     accepted;
    idx_t     server_index;
    load_t    result_tag;

    least_loaded_server_assigner_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request_tag   (request_tag),
        .request_size  (request_size),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .accepted      (accepted),
        .server_index  (server_index),
        .result_tag    (result_tag)
    );

    load_t srv_load [SERVER_COUNT];
    rank_t srv_rank [SERVER_COUNT];
    load_t srv_cap  [CAPACITY_REGS];

    assignment_t due_assignments [$];
    int          mismatches    = 0;
    bit          calm_stretch  = 1'b0;
    bit          hold_results  = 1'b0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_REQUEST, 16'h0000, 16'h0000, 1'b1, 1'b1, 3'd0},  // zero size right after reset
        '{ROW_REQUEST, 16'hffff, 16'hffff, 1'b1, 1'b1, 3'd1},  // fills server 1 to its cap
        '{ROW_REQUEST, 16'h8000, 16'h0001, 1'b1, 1'b1, 3'd2},
        '{ROW_REQUEST, 16'h00ff, 16'h7fff, 1'b0, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'hff00, 16'h8000, 1'b0, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'h5555, 16'haaaa, 1'b0, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'haaaa, 16'h5555, 1'b0, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'h0f0f, 16'hffff, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_0), 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_1), 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_2), 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_3), 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_4), 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_5), 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_6), 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(CAPACITY_7), 16'h0000, 1'b0, 1'b0, 3'd0},
        // out-of-range indexes must not reopen any server
        '{ROW_WRITE, 16'(LAST_UNUSED_IDX), 16'hffff, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, 16'(FIRST_UNUSED_IDX), 16'hffff, 1'b0, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'h1357, 16'h0001, 1'b1, 1'b0, 3'd0},  // every cap zero: rejected
        '{ROW_REQUEST, 16'h0000, 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'h2468, 16'h8000, 1'b1, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'hffff, 16'hffff, 1'b1, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'h4321, 16'h0000, 1'b0, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'h7777, 16'h0002, 1'b1, 1'b0, 3'd0},
        '{ROW_REQUEST, 16'h8888, 16'h0000, 1'b0, 1'b0, 3'd0}
    };

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // lowest load, then least recently served, then lowest index
    function automatic idx_t least_loaded();
        idx_t best;
        best = '0;
        for (int i = 1; i < SERVER_COUNT; i++)
        begin
            if (srv_load[i] < srv_load[best] ||
                (srv_load[i] == srv_load[best] && srv_rank[i] < srv_rank[best]))
                best = idx_t'(i);
        end
        return best;
    endfunction

    function automatic assignment_t assign_request(input load_t tag, input load_t size);
        assignment_t outcome;
        idx_t        best;
        rank_t       prior;
        logic [16:0] total;
        best  = least_loaded();
        total = {1'b0, srv_load[best]} + {1'b0, size};
        outcome.tag      = tag;
        outcome.accepted = 1'b0;
        outcome.server   = '0;
        if (total > {1'b0, srv_cap[best]})
            return outcome;
        srv_load[best] = total[15:0];
        prior = srv_rank[best];
        for (int i = 0; i < SERVER_COUNT; i++)
        begin
            if (srv_rank[i] > prior)
                srv_rank[i] = srv_rank[i] - 1'b1;
        end
        srv_rank[best]   = rank_t'(SERVER_COUNT - 1);
        outcome.accepted = 1'b1;
        outcome.server   = best;
        return outcome;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic offer_request(input load_t tag, input load_t size, input bit typed,
                                 input logic want_acc, input idx_t want_idx);
        int          gap;
        assignment_t outcome;
        gap = calm_stretch ? 0 : pick_gap();
        if (gap > 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_valid <= 1'b1;
        request_tag   <= tag;
        request_size  <= size;
        @(posedge clk);
        while (!request_ready)
            @(posedge clk);
        outcome = assign_request(tag, size);
        if (typed)
        begin
            outcome.accepted = want_acc;
            outcome.server   = want_idx;
        end
        due_assignments.insert(due_assignments.size(), outcome);
    endtask

    // called at a clock edge, right after a request was taken or a register written
    task automatic settle_results();
        request_valid <= 1'b0;
        while (due_assignments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input cfg_idx_t idxs [$], input load_t vals [$]);
        foreach (idxs[k])
        begin
            cfg_write <= 1'b1;
            cfg_index <= idxs[k];
            cfg_data  <= vals[k];
            if (idxs[k] < CAPACITY_REGS)
                srv_cap[idxs[k][2:0]] = vals[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        cfg_idx_t    idxs [$];
        load_t       vals [$];
        load_t       tag;
        load_t       size;
        logic [16:0] room;
        idx_t        best;
        int          r;

        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        request_valid = 1'b0;
        request_tag   = '0;
        request_size  = '0;
        result_ready  = 1'b0;
        for (int i = 0; i < SERVER_COUNT; i++)
        begin
            srv_load[i] = '0;
            srv_rank[i] = rank_t'(i);
        end
        for (int i = 0; i < CAPACITY_REGS; i++)
            srv_cap[i] = 16'hffff;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_WRITE)
            begin
                settle_results();
                idxs.delete();
                vals.delete();
                idxs.insert(idxs.size(), cfg_idx_t'(plan[n].tag_idx));
                vals.insert(vals.size(), plan[n].size_data);
                program_registers(idxs, vals);
            end
            else
            begin
                offer_request(plan[n].tag_idx, plan[n].size_data, plan[n].typed,
                              plan[n].want_acc, plan[n].want_idx);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_results();
            idxs.delete();
            vals.delete();
            for (int i = 0; i < CAPACITY_REGS; i++)
            begin
                case (ph)
                    0, HOLD_PHASE:
                        room = 17'h0ffff;
                    1:
                        room = {1'b0, srv_load[i]} + 17'($urandom_range(0, 3000));
                    DRAIN_PHASE:
                    begin
                        r = $urandom_range(0, 2);
                        if (r == 0)
                            room = '0;
                        else if (r == 1)
                            room = 17'h0ffff;
                        else
                            room = {1'b0, srv_load[i]} + 17'($urandom_range(0, 500));
                    end
                    4:
                        room = {1'b0, srv_load[i]} +
                               ((i % 2 == 0) ? 17'd0 : 17'($urandom_range(0, 20000)));
                    default:
                        room = 17'($urandom_range(0, 65535));
                endcase
                idxs.insert(idxs.size(), cfg_idx_t'(i));
                vals.insert(vals.size(), room[16] ? 16'hffff : room[15:0]);
            end
            repeat (2)
            begin
                idxs.insert(idxs.size(),
                            cfg_idx_t'($urandom_range(FIRST_UNUSED_IDX, LAST_UNUSED_IDX)));
                vals.insert(vals.size(), load_t'($urandom()));
            end
            program_registers(idxs, vals);
            calm_stretch = (ph == HOLD_PHASE);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == HOLD_PHASE && n == 40)
                    hold_results = 1'b1;
                if (ph == DRAIN_PHASE && n == 100)
                    settle_results();
                tag = load_t'($urandom());
                r   = $urandom_range(0, 99);
                if (r < 10)
                    size = '0;
                else if (r < 70)
                    size = load_t'($urandom_range(1, 63));
                else if (r < 85)
                begin
                    // aim at the fit boundary of the server that will be picked
                    best = least_loaded();
                    room = {1'b0, srv_cap[best]} - {1'b0, srv_load[best]};
                    if (srv_cap[best] < srv_load[best] || room > 17'd4095)
                        size = load_t'($urandom_range(0, 3));
                    else
                        size = room[15:0] + load_t'($urandom_range(0, 1));
                end
                else if (r < 99)
                    size = load_t'($urandom_range(64, 2047));
                else
                    size = load_t'($urandom());
                offer_request(tag, size, 1'b0, 1'b0, '0);
            end
        end

        settle_results();
        if (mismatches == 0 && due_assignments.size() == 0)
            $display("** least_loaded_server_assigner_core: PASSED **");
        else
            $display("** least_loaded_server_assigner_core: FAILED **");
        $finish;
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                stall_left   = HOLD_CYCLES;
                hold_results = 1'b0;
            end
            if (stall_left == 0 && !calm_stretch && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        assignment_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (due_assignments.size() == 0)
            begin
                flag_mismatch("result with no request pending, tag", '0, 32'(result_tag));
            end
            else
            begin
                want = due_assignments.pop_front();
                if (accepted !== want.accepted)
                    flag_mismatch("accepted", 32'(want.accepted), 32'(accepted));
                if (server_index !== want.server)
                    flag_mismatch("server_index", 32'(want.server), 32'(server_index));
                if (result_tag !== want.tag)
                    flag_mismatch("result_tag", 32'(want.tag), 32'(result_tag));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((request_valid && request_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("** least_loaded_server_assigner_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
